### rtl/core/lge_pkg.sv
// Shared types, opcodes and helpers for the life grid generation engine.
package lge_pkg;

    localparam int ROW_W  = 64;
    localparam int IDX_W  = 6;
    localparam int SIZE_W = 7;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_cells;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] read_row_index;
        logic [ROW_W-1:0] read_row_cells;
    } out_item_t;

    // Region trim broadcast to every cell on a size register write.
    typedef struct packed {
        logic              clear_en;
        logic [SIZE_W-1:0] rows_eff;
        logic [ROW_W-1:0]  col_mask;
    } trim_t;

    function automatic logic [ROW_W-1:0] col_mask_f(input logic [SIZE_W-1:0] cols);
        logic [ROW_W-1:0] m;
        for (int k = 0; k < ROW_W; k++)
        begin
            m[k] = (SIZE_W'(k) < cols);
        end
        return m;
    endfunction

endpackage

### rtl/core/lge_cell.sv
// One row cell of the rotating grid chain.
module lge_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift_en,
    input  logic [lge_pkg::ROW_W-1:0] shift_in,
    input  lge_pkg::trim_t           trim,
    output logic [lge_pkg::ROW_W-1:0] row
);
    import lge_pkg::*;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    always_comb
    begin
        row_next = row_reg;
        if (trim.clear_en)
        begin
            row_next = (SIZE_W'(CELL_IDX) < trim.rows_eff) ? (row_reg & trim.col_mask)
                                                           : '0;
        end
        else if (shift_en)
        begin
            row_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row = row_reg;

endmodule

### rtl/core/lge_rule.sv
// B3/S23 next-row unit with the saved pre-update row above.
module lge_rule (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift_en,
    input  logic                     first_row,
    input  logic                     below_use,
    input  logic [lge_pkg::ROW_W-1:0] cur_row,
    input  logic [lge_pkg::ROW_W-1:0] below_row,
    input  logic [lge_pkg::ROW_W-1:0] col_mask,
    output logic [lge_pkg::ROW_W-1:0] next_row
);
    import lge_pkg::*;

    logic [ROW_W-1:0] prev_reg;
    logic [ROW_W-1:0] up;
    logic [ROW_W-1:0] dn;
    logic [ROW_W-1:0] life;
    logic [3:0]       n;

    assign up = first_row ? '0 : prev_reg;
    assign dn = below_use ? below_row : '0;

    always_comb
    begin
        life = '0;
        for (int k = 0; k < ROW_W; k++)
        begin
            n = 4'(up[k]) + 4'(dn[k]);
            if (k > 0)
            begin
                n = n + 4'(up[k-1]) + 4'(cur_row[k-1]) + 4'(dn[k-1]);
            end
            if (k < ROW_W - 1)
            begin
                n = n + 4'(up[k+1]) + 4'(cur_row[k+1]) + 4'(dn[k+1]);
            end
            life[k] = (n == 4'd3) || (cur_row[k] && (n == 4'd2));
        end
    end

    assign next_row = life & col_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (shift_en)
        begin
            prev_reg <= cur_row;
        end
    end

endmodule

### rtl/core/life_grid_generation_engine.sv
// Top level: chain of row cells rotated once per item through the rule unit.
// Every item rotates the whole chain once after accept.
// A read result is registered on the last rotation step.
// A new item is taken only when idle; the chain rotates one row per cycle unless the last step waits.
// The last step of a read waits while a previous result is still stalled at the output.
// Reset (rst_n, async low): all cells dead, both sizes 60, idle, no result pending.
module life_grid_generation_engine #(
    parameter int GRID_SIZE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lge_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lge_pkg::out_item_t              out_item,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [lge_pkg::SIZE_W-1:0]      cfg_data
);
    import lge_pkg::*;

    localparam int STEP_W = $clog2(GRID_SIZE);
    localparam logic [SIZE_W-1:0] GSIZE = SIZE_W'(GRID_SIZE);

    logic [SIZE_W-1:0] rows_reg, cols_reg;
    logic [SIZE_W-1:0] rows_eff, cols_eff, new_eff;
    logic [ROW_W-1:0]  mask;
    trim_t             trim;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    in_item_t          item_reg;
    logic [ROW_W-1:0]  hold_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic [ROW_W-1:0]  rows   [GRID_SIZE];
    logic [ROW_W-1:0]  rule_row;
    logic [ROW_W-1:0]  tail_in;
    logic              last_step, is_read, shift_en, accept;
    logic              in_use, below_use, hit;
    logic [SIZE_W-1:0] step_x;

    assign rows_eff = (rows_reg > GSIZE) ? GSIZE : rows_reg;
    assign cols_eff = (cols_reg > GSIZE) ? GSIZE : cols_reg;
    assign new_eff  = (cfg_data > GSIZE) ? GSIZE : cfg_data;
    assign mask     = col_mask_f(cols_eff);

    always_comb
    begin
        trim.clear_en = cfg_we;
        trim.rows_eff = rows_eff;
        trim.col_mask = mask;
        if (cfg_index == CFG_ROWS)
        begin
            trim.rows_eff = new_eff;
        end
        else
        begin
            trim.col_mask = col_mask_f(new_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= SIZE_W'(60);
            cols_reg <= SIZE_W'(60);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROWS)
            begin
                rows_reg <= cfg_data;
            end
            else
            begin
                cols_reg <= cfg_data;
            end
        end
    end

    assign step_x    = SIZE_W'(step_reg);
    assign last_step = (step_reg == STEP_W'(GRID_SIZE - 1));
    assign is_read   = (item_reg.opcode == OP_READ);
    assign shift_en  = busy_reg && !(last_step && is_read && out_valid_reg && out_stall);
    assign accept    = in_valid && !busy_reg;
    assign in_use    = step_x < rows_eff;
    assign below_use = (step_x + SIZE_W'(1)) < rows_eff;
    assign hit       = ({1'b0, item_reg.row_index} == step_x);

    lge_rule u_rule (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .first_row (step_reg == '0),
        .below_use (below_use),
        .cur_row   (rows[0]),
        .below_row (rows[1]),
        .col_mask  (mask),
        .next_row  (rule_row)
    );

    always_comb
    begin
        tail_in = rows[0];
        unique case (item_reg.opcode)
            OP_ADVANCE:
            begin
                if (in_use)
                begin
                    tail_in = rule_row;
                end
            end
            OP_WRITE:
            begin
                if (in_use && hit)
                begin
                    tail_in = item_reg.row_cells & mask;
                end
            end
            default:
            begin
                tail_in = rows[0];
            end
        endcase
    end

    for (genvar j = 0; j < GRID_SIZE; j++)
    begin : g_cell
        lge_cell #(
            .CELL_IDX (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .shift_in ((j == GRID_SIZE - 1) ? tail_in : rows[(j + 1) % GRID_SIZE]),
            .trim     (trim),
            .row      (rows[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (shift_en)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (shift_en && last_step && is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (shift_en && hit)
        begin
            hold_reg <= in_use ? (rows[0] & mask) : '0;
        end
        if (shift_en && last_step && is_read)
        begin
            out_item_reg.read_row_index <= item_reg.row_index;
            out_item_reg.read_row_cells <= ({1'b0, item_reg.row_index} < rows_eff)
                                         ? (hit ? (rows[0] & mask) : hold_reg) : '0;
        end
    end

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### rtl/core/lge_checker.sv
// Port-level checks for the life grid generation engine, bound to the top level.
module lge_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  lge_pkg::out_item_t  out_item
);
    import lge_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("engine not busy after accepting an item");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("input still stalled when read result issued");

endmodule

bind life_grid_generation_engine lge_checker u_lge_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
